// File: rtl/mfbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit reader package
// Shared sizes, operation and status codes, and the item and queue entry
// types used by the front, the queue and the back of the reader.
// ----------------------------------------------------------------------------
package mfbr_pkg;

  // Buffer geometry.
  localparam int BUFFER_BYTES = 16;
  localparam int CAP_BITS     = BUFFER_BYTES * 8;
  localparam int POS_W        = $clog2(CAP_BITS);
  localparam int HELD_W       = $clog2(CAP_BITS + 1);
  localparam int WPTR_W       = $clog2(BUFFER_BYTES);

  // Field limits.
  localparam int FIELD_BITS   = 64;
  localparam int COUNT_W      = 7;

  // Queue between front and back.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_READ = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         byte_in;
    logic [COUNT_W-1:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] value;
    logic [1:0]            status;
    logic [7:0]            bits_available;
  } out_item_t;

  // Classified item: the 64-bit window at the read position and the number
  // of bits to keep from its top. A count of zero gives a zero value.
  typedef struct packed {
    logic [FIELD_BITS-1:0] window;
    logic [COUNT_W-1:0]    count;
    logic [1:0]            status;
    logic [7:0]            bits_available;
  } entry_t;

endpackage

// File: rtl/msb_first_bit_reader_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit reader
// Bitstream reader over a 16-byte circular buffer: push bytes, then read or
// peek 0 to 64 bits at a time, first stream bit most significant.
// ----------------------------------------------------------------------------
// The reader takes one item every clock cycle while full is low and gives
// one result item for each, in order. A result passes through a queue slot
// and then the output register, entering it when that register is empty or
// being popped. The front updates the buffer state for an item in the cycle
// it is accepted, so items depend on each other without extra delay; the
// critical path is the barrel rotation of the whole byte store to the read
// position in the front. A two-entry queue and the output register let either
// side stall alone; full rises only when both queue entries are occupied. There
// is no clearing pass after reset: unread bits are only ever pushed bytes.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mfbr_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output mfbr_pkg::out_item_t result
);
  import mfbr_pkg::*;

  logic   q_wr;
  logic   q_full;
  logic   q_valid;
  logic   q_rd;
  entry_t q_data;
  entry_t q_head;

  // Front: accept and classify.
  mfbr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (q_data)
  );

  // Queue between the two sides.
  mfbr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_data),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd      (q_rd),
    .head    (q_head)
  );

  // Back: align and deliver.
  mfbr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (q_head),
    .rd      (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: rtl/mfbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit reader front
// Accepts items, keeps the byte store and the read and write positions,
// decides each item's status and snapshots the bit window it needs.
// ----------------------------------------------------------------------------
module mfbr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mfbr_pkg::in_item_t request,
  input  logic              q_full,
  output logic              q_wr,
  output mfbr_pkg::entry_t  q_data
);
  import mfbr_pkg::*;

  logic [7:0]          store [BUFFER_BYTES];
  logic [POS_W-1:0]    rpos;
  logic [POS_W-1:0]    rpos_next;
  logic [WPTR_W-1:0]   wptr;
  logic [WPTR_W-1:0]   wptr_next;
  logic [HELD_W-1:0]   held;
  logic [HELD_W-1:0]   held_next;

  logic                accept;
  logic                store_we;
  logic [COUNT_W-1:0]  count_sat;
  logic [HELD_W-1:0]   count_h;
  logic [HELD_W:0]     held_plus;
  logic [POS_W:0]      rpos_sum;
  logic [CAP_BITS-1:0] stream;
  logic [2*CAP_BITS-1:0] rotated;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  keep;

  assign full   = q_full;
  assign accept = push && !full;

  // Requested count, saturated to the field width.
  assign count_sat = (request.bit_count > COUNT_W'(FIELD_BITS)) ?
                     COUNT_W'(FIELD_BITS) : request.bit_count;
  assign count_h   = HELD_W'(count_sat);
  assign held_plus = {1'b0, held} + (HELD_W + 1)'(8);

  // Lay the store out in stream order, first bit on top, and rotate the
  // read position to the top to form the window.
  always_comb begin
    for (int k = 0; k < BUFFER_BYTES; k++) begin
      stream[CAP_BITS - 1 - 8 * k -: 8] = store[k];
    end
  end
  assign rotated = {stream, stream} << rpos;

  // Read position advance, modulo the capacity.
  assign rpos_sum = {1'b0, rpos} + (POS_W + 1)'(count_sat);

  // Classification and bookkeeping.
  always_comb begin
    rpos_next = rpos;
    wptr_next = wptr;
    held_next = held;
    store_we  = 1'b0;
    status    = ST_OK;
    keep      = '0;
    case (request.operation)
      OP_PUSH: begin
        if (held_plus > (HELD_W + 1)'(CAP_BITS)) begin
          status = ST_FULL;
        end else begin
          store_we  = 1'b1;
          wptr_next = (wptr == WPTR_W'(BUFFER_BYTES - 1)) ? '0 : wptr + 1'b1;
          held_next = held_plus[HELD_W-1:0];
        end
      end
      OP_READ, OP_PEEK: begin
        if (count_h > held) begin
          status = ST_UNDERFLOW;
        end else begin
          keep = count_sat;
          if (request.operation == OP_READ) begin
            held_next = held - count_h;
            if (rpos_sum >= (POS_W + 1)'(CAP_BITS)) begin
              rpos_next = POS_W'(rpos_sum - (POS_W + 1)'(CAP_BITS));
            end else begin
              rpos_next = rpos_sum[POS_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Entry handed to the back.
  assign q_wr                  = accept;
  assign q_data.window         = rotated[2*CAP_BITS-1 -: FIELD_BITS];
  assign q_data.count          = keep;
  assign q_data.status         = status;
  assign q_data.bits_available = 8'(held_next);

  // Position and fill state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rpos <= '0;
      wptr <= '0;
      held <= '0;
    end else if (accept) begin
      rpos <= rpos_next;
      wptr <= wptr_next;
      held <= held_next;
    end
  end

  // Byte store write.
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      store[wptr] <= request.byte_in;
    end
  end

`ifndef SYNTHESIS
  a_held_in_range: assert property (@(posedge clk) disable iff (rst)
    held <= HELD_W'(CAP_BITS))
    else $error("held bit count above capacity");

  a_read_consumes: assert property (@(posedge clk) disable iff (rst)
    (accept && request.operation == OP_READ && count_h <= held)
    |=> held == $past(held) - $past(count_h))
    else $error("read did not consume its bits");
`endif

endmodule

// File: rtl/mfbr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit reader queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module mfbr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mfbr_pkg::entry_t wr_data,
  output logic             q_full,
  output logic             q_valid,
  input  logic             rd,
  output mfbr_pkg::entry_t head
);
  import mfbr_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  // The window may carry unwritten store bits, so compare them exactly.
  a_first_at_head: assert property (@(posedge clk) disable iff (rst)
    (wr && count == '0 && !rd) |=> (q_valid && head === $past(wr_data)))
    else $error("item written to empty queue is not at the head");
`endif

endmodule

// File: rtl/mfbr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit reader back
// Right-aligns the requested bits of each window and holds the result item
// in an output register until it is popped.
// ----------------------------------------------------------------------------
module mfbr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  mfbr_pkg::entry_t    head,
  output logic                rd,
  output logic                empty,
  input  logic                pop,
  output mfbr_pkg::out_item_t result
);
  import mfbr_pkg::*;

  logic      out_valid;
  out_item_t aligned;

  assign empty = !out_valid;
  assign rd    = q_valid && (!out_valid || pop);

  // Keep the top count bits of the window; a zero count shifts all out.
  assign aligned.value          = head.window >> (COUNT_W'(FIELD_BITS) - head.count);
  assign aligned.status         = head.status;
  assign aligned.bits_available = head.bits_available;

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (rd) begin
      result <= aligned;
    end
  end

`ifndef SYNTHESIS
  a_fail_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.status != ST_OK) |-> result.value == '0)
    else $error("failed item carries a nonzero value");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit reader testbench
// Sends push, read, peek and unused items through the queue-style request
// port and checks every result against a shadow of the circular byte
// buffer, field by field. Covers empty and full buffer edges, count
// saturation, wrap-around and back-pressure from a long stall on pop.
// ----------------------------------------------------------------------------
module testbench;
  import mfbr_pkg::*;

  // Operation code that the block treats as a no-op.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int MAX_GAP = 13;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  request;
  logic      empty;
  logic      pop;
  out_item_t result;

  // Shadow of the reader state.
  logic [7:0]  shadow_store [BUFFER_BYTES];
  int unsigned rd_bit_pos;
  int unsigned wr_byte_pos;
  int unsigned held_bits;

  out_item_t awaited_results [$];
  int        mismatches;
  int        cycle_count;
  bit        tx_idle;
  bit        rx_idle;
  int        rx_hold_cycles;

  msb_first_bit_reader_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .request(request),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Computes the result of one item and advances the shadow state.
  function automatic out_item_t predict_bit_read(in_item_t it);
    out_item_t   expected;
    int unsigned count;
    int unsigned pos;
    expected = '0;
    count = 32'(it.bit_count);
    case (it.operation)
      OP_PUSH: begin
        if (held_bits + 8 > CAP_BITS) begin
          expected.status = ST_FULL;
        end else begin
          shadow_store[WPTR_W'(wr_byte_pos)] = it.byte_in;
          wr_byte_pos = (wr_byte_pos + 1) % BUFFER_BYTES;
          held_bits += 8;
        end
      end
      OP_READ, OP_PEEK: begin
        if (count > FIELD_BITS) count = FIELD_BITS;
        if (count > held_bits) begin
          expected.status = ST_UNDERFLOW;
        end else begin
          // Gather bits in stream order; bit 7 of each byte comes first.
          for (int i = 0; i < count; i++) begin
            pos = (rd_bit_pos + i) % CAP_BITS;
            expected.value = {expected.value[FIELD_BITS-2:0],
                              shadow_store[WPTR_W'(pos >> 3)][~pos[2:0]]};
          end
          if (it.operation == OP_READ) begin
            rd_bit_pos = (rd_bit_pos + count) % CAP_BITS;
            held_bits -= count;
          end
        end
      end
      default: ;
    endcase
    expected.bits_available = held_bits[7:0];
    return expected;
  endfunction

  function automatic in_item_t request_of(logic [1:0] op, logic [7:0] b, logic [6:0] c);
    in_item_t it;
    it.operation = op;
    it.byte_in = b;
    it.bit_count = c;
    return it;
  endfunction

  // Random item shaped by the current fill level: most counts fit the
  // buffered bits, some are drawn over the full field range.
  function automatic in_item_t random_request(int push_pct);
    in_item_t    it;
    int          r;
    int unsigned room;
    it.byte_in = 8'($urandom);
    it.bit_count = 7'($urandom);
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      it.operation = OP_PUSH;
    end else if (r < 97) begin
      it.operation = $urandom_range(0, 1) ? OP_READ : OP_PEEK;
    end else begin
      it.operation = OP_NONE;
    end
    if ($urandom_range(0, 7) != 0) begin
      room = (held_bits > FIELD_BITS) ? FIELD_BITS : held_bits;
      it.bit_count = 7'($urandom_range(0, room));
    end
    return it;
  endfunction

  // Offers one item after an optional gap and waits until it is taken.
  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    request <= it;
    do @(posedge clk); while (full);
    awaited_results.push_back(predict_bit_read(it));
  endtask

  task automatic check_result(out_item_t got);
    out_item_t expected;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result: got value %h status %0d bits %0d",
               $time, got.value, got.status, got.bits_available);
      mismatches++;
    end else begin
      expected = awaited_results.pop_front();
      if (got.value !== expected.value) begin
        $display("%0t: value mismatch: expected %h, got %h",
                 $time, expected.value, got.value);
        mismatches++;
      end
      if (got.status !== expected.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, expected.status, got.status);
        mismatches++;
      end
      if (got.bits_available !== expected.bits_available) begin
        $display("%0t: bits_available mismatch: expected %0d, got %0d",
                 $time, expected.bits_available, got.bits_available);
        mismatches++;
      end
    end
  endtask

  // Empty buffer, filling to capacity, a dropped push, count saturation.
  task automatic test_directed_edges();
    logic [7:0] pattern [16];
    pattern = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'h7E, 8'hC3,
                8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h3C, 8'h96, 8'h69, 8'hE7};
    send_item(request_of(OP_READ, 8'h00, 7'd1));
    send_item(request_of(OP_PEEK, 8'hFF, 7'd64));
    send_item(request_of(OP_NONE, 8'hFF, 7'd127));
    send_item(request_of(OP_READ, 8'h00, 7'd0));
    foreach (pattern[i]) send_item(request_of(OP_PUSH, pattern[i], 7'($urandom)));
    send_item(request_of(OP_PUSH, 8'hFF, 7'd0));
    send_item(request_of(OP_PEEK, 8'h00, 7'd127));
    send_item(request_of(OP_READ, 8'h00, 7'd64));
    send_item(request_of(OP_READ, 8'h00, 7'd65));
    send_item(request_of(OP_READ, 8'h00, 7'd1));
  endtask

  // Random stream; unused operations do not count toward the total.
  task automatic test_random_stream(int total, int push_pct);
    in_item_t it;
    int       sent;
    sent = 0;
    while (sent < total) begin
      it = random_request(push_pct);
      send_item(it);
      if (it.operation != OP_NONE) sent++;
    end
  endtask

  // The receiver stalls for a long stretch while items keep coming.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 300;
    test_random_stream(100, 50);
  endtask

  // Push-heavy traffic that keeps the buffer at capacity.
  task automatic test_full_buffer();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    test_random_stream(250, 75);
  endtask

  // Back-to-back items on both sides.
  task automatic test_no_idle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_stream(400, 40);
  endtask

  // Read-heavy traffic that keeps the buffer near empty.
  task automatic test_drain();
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    test_random_stream(250, 20);
  endtask

  // Result side: optional long hold, a random gap, then take one item.
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result(result);
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    request = '0;
    mismatches = 0;
    rx_hold_cycles = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    rd_bit_pos = 0;
    wr_byte_pos = 0;
    held_bits = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_random_stream(600, 40);
    test_backpressure();
    test_full_buffer();
    test_no_idle();
    test_drain();
    push <= 1'b0;

    // Wait for the last results, then let the pipeline settle.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
